// File: design/paged_frame_allocator_top_macros.svh
// Assertion macros for the paged frame allocator.
`ifndef PAGED_FRAME_ALLOCATOR_TOP_MACROS_SVH
`define PAGED_FRAME_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PFA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PFA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define PFA_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define PFA_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

// File: design/pfa_pkg.sv
package pfa_pkg;
    localparam int unsigned REQ_W = 2;
    localparam int unsigned ST_W  = 3;
    localparam int unsigned PS_W  = 17;

    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE    = 2'd0,
        REQ_FINISH    = 2'd1,
        REQ_RESIZE    = 2'd2,
        REQ_TRANSLATE = 2'd3
    } req_t;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_NOPROC  = 3'd1;
    localparam logic [ST_W-1:0] ST_OOM     = 3'd2;
    localparam logic [ST_W-1:0] ST_BADPAGE = 3'd3;
    localparam logic [ST_W-1:0] ST_NOSLOT  = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] pid;
        logic [23:0] new_size;
        logic [15:0] page_number;
    } req_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] frame;
        logic [8:0] free_frames;
    } rsp_word_t;

    // Divider handshake between the sequencer and the divider.
    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;
endpackage

// File: design/pfa_req_if.sv
interface pfa_req_if;
    logic                valid;
    logic                ready;
    pfa_pkg::req_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/pfa_rsp_if.sv
interface pfa_rsp_if;
    logic                valid;
    logic                ready;
    pfa_pkg::rsp_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/pfa_ram.sv
module pfa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/pfa_div.sv
// Restoring divider, one quotient bit per cycle; returns ceil(num/den).
module pfa_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [23:0] num,
    input  logic [16:0] den,
    output logic        done,
    output logic [23:0] quo
);
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [23:0] q_reg;
    logic [17:0] rem_reg;
    logic [16:0] den_reg;
    logic [17:0] trial;
    logic        fin_reg;

    assign trial = {rem_reg[16:0], q_reg[23]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
                q_reg    <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                if (!trial[17])
                begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[16:0], q_reg[23]};
                    q_reg   <= {q_reg[22:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd23)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    assign done = fin_reg;
    assign quo  = q_reg + {23'd0, (rem_reg != '0)};
endmodule

// File: design/paged_frame_allocator_top.sv
// Channel  Dir  Fields
// req      in   req_type, pid, new_size, page_number
// rsp      out  status, frame, free_frames
// One request at a time under a sequencer, which first searches the process slots.
// Resize runs the divider, then scans the frame bitmap to grow or frees pages one at a
// time to shrink; finish frees its pages one at a time.
// Reset is asynchronous, active low; it clears the bitmap, slots and counts at once.
// A result waits in the output register; req is not ready until it is taken.
`include "paged_frame_allocator_top_macros.svh"
module paged_frame_allocator_top #(
    parameter int unsigned NUM_FRAMES = 256,
    parameter int unsigned MAX_PROCS  = 16,
    parameter int unsigned MAX_PAGES  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    pfa_req_if.sink     req,
    pfa_rsp_if.source   rsp
);
    localparam int unsigned FW = $clog2(NUM_FRAMES);
    localparam int unsigned CW = $clog2(NUM_FRAMES + 1);
    localparam int unsigned SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int unsigned PW = $clog2(MAX_PAGES + 1);
    localparam int unsigned XW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int unsigned AW = $clog2(MAX_PROCS * MAX_PAGES) > 0 ?
                                 $clog2(MAX_PROCS * MAX_PAGES) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_DISPATCH, S_DIV, S_DECIDE, S_SHRINK_RD, S_SHRINK,
        S_GROW, S_XL_RD, S_XL, S_RESP
    } state_t;

    state_t                 state_reg;
    pfa_pkg::req_word_t     rq_reg;
    logic [16:0]            page_size_reg;
    logic [NUM_FRAMES-1:0]  used_reg;
    logic [CW-1:0]          free_reg;
    logic [MAX_PROCS-1:0]   valid_reg;
    logic [15:0]            owner_reg [MAX_PROCS];
    logic [PW-1:0]          pcnt_reg  [MAX_PROCS];
    logic [SW:0]            scan_reg;
    logic                   hit_reg, empty_found_reg;
    logic [SW-1:0]          hit_slot_reg, empty_slot_reg;
    logic [FW:0]            fscan_reg;
    logic [PW-1:0]          keep_reg;
    logic [23:0]            want_reg;
    pfa_pkg::rsp_word_t     out_reg;
    logic                   out_valid_reg;
    logic                   div_start;
    pfa_pkg::div_ctl_t      dctl;
    logic [23:0]            div_q;
    logic [16:0]            ps_eff;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [7:0]             ram_wdata, ram_rdata;
    logic [SW-1:0]          cur;
    logic [PW-1:0]          cur_cnt;

    assign cur     = hit_slot_reg;
    assign cur_cnt = pcnt_reg[cur];
    assign ps_eff  = (page_size_reg == '0) ? 17'd1 :
                     (page_size_reg > 17'd65536) ? 17'd65536 : page_size_reg;
    assign div_start  = (state_reg == S_DISPATCH) &&
                        (pfa_pkg::req_t'(rq_reg.req_type) == pfa_pkg::REQ_RESIZE);
    assign dctl.start = div_start;

    pfa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (rq_reg.new_size),
        .den   (ps_eff),
        .done  (dctl.done),
        .quo   (div_q)
    );

    pfa_ram #(.WIDTH(8), .DEPTH(MAX_PROCS * MAX_PAGES)) u_tbl (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [PW-1:0] last_pg;
    assign last_pg   = cur_cnt - PW'(1);
    assign ram_we    = (state_reg == S_GROW) && !used_reg[fscan_reg[FW-1:0]] &&
                       (PW'(cur_cnt) < PW'(want_reg)) && !fscan_reg[FW];
    assign ram_waddr = AW'(cur * MAX_PAGES + cur_cnt);
    assign ram_wdata = 8'(fscan_reg[FW-1:0]);
    assign ram_raddr = (state_reg == S_XL_RD) ?
                       AW'(cur * MAX_PAGES + rq_reg.page_number[XW-1:0]) :
                       AW'(cur * MAX_PAGES + last_pg);

    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            page_size_reg <= 17'd32;
            used_reg      <= '0;
            free_reg      <= CW'(NUM_FRAMES);
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_PROCS; i++)
            begin
                pcnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                page_size_reg <= cfg_wdata;
            end
            if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        rq_reg          <= req.data;
                        scan_reg        <= '0;
                        hit_reg         <= 1'b0;
                        empty_found_reg <= 1'b0;
                        out_reg.status  <= pfa_pkg::ST_OK;
                        out_reg.frame   <= '0;
                        state_reg       <= S_FIND;
                    end
                end
                S_FIND:
                begin
                    if (scan_reg == (SW+1)'(MAX_PROCS))
                    begin
                        state_reg <= S_DISPATCH;
                    end
                    else
                    begin
                        if (valid_reg[scan_reg[SW-1:0]] &&
                            owner_reg[scan_reg[SW-1:0]] == rq_reg.pid)
                        begin
                            hit_reg      <= 1'b1;
                            hit_slot_reg <= scan_reg[SW-1:0];
                        end
                        if (!valid_reg[scan_reg[SW-1:0]] && !empty_found_reg)
                        begin
                            empty_found_reg <= 1'b1;
                            empty_slot_reg  <= scan_reg[SW-1:0];
                        end
                        scan_reg <= scan_reg + (SW+1)'(1);
                    end
                end
                S_DISPATCH:
                begin
                    if (pfa_pkg::req_t'(rq_reg.req_type) == pfa_pkg::REQ_CREATE)
                    begin
                        if (!hit_reg)
                        begin
                            if (!empty_found_reg)
                            begin
                                out_reg.status <= pfa_pkg::ST_NOSLOT;
                            end
                            else
                            begin
                                valid_reg[empty_slot_reg] <= 1'b1;
                                owner_reg[empty_slot_reg] <= rq_reg.pid;
                                pcnt_reg[empty_slot_reg]  <= '0;
                            end
                        end
                        state_reg <= S_RESP;
                    end
                    else if (!hit_reg)
                    begin
                        out_reg.status <= pfa_pkg::ST_NOPROC;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        unique case (pfa_pkg::req_t'(rq_reg.req_type))
                            pfa_pkg::REQ_FINISH:
                            begin
                                keep_reg  <= '0;
                                state_reg <= S_SHRINK_RD;
                            end
                            pfa_pkg::REQ_RESIZE:    state_reg <= S_DIV;
                            pfa_pkg::REQ_TRANSLATE: state_reg <= S_XL_RD;
                            default:                state_reg <= S_RESP;
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (dctl.done)
                    begin
                        want_reg  <= div_q;
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    fscan_reg <= '0;
                    if (want_reg > 24'(MAX_PAGES))
                    begin
                        out_reg.status <= pfa_pkg::ST_OOM;
                        state_reg      <= S_RESP;
                    end
                    else if (want_reg <= 24'(cur_cnt))
                    begin
                        keep_reg  <= PW'(want_reg);
                        state_reg <= S_SHRINK_RD;
                    end
                    else if (want_reg - 24'(cur_cnt) > 24'(free_reg))
                    begin
                        out_reg.status <= pfa_pkg::ST_OOM;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_GROW;
                    end
                end
                S_SHRINK_RD:
                begin
                    if (cur_cnt > keep_reg)
                    begin
                        state_reg <= S_SHRINK;
                    end
                    else
                    begin
                        if (pfa_pkg::req_t'(rq_reg.req_type) == pfa_pkg::REQ_FINISH)
                        begin
                            valid_reg[cur] <= 1'b0;
                        end
                        state_reg <= S_RESP;
                    end
                end
                S_SHRINK:
                begin
                    if (32'(ram_rdata) < NUM_FRAMES && used_reg[FW'(ram_rdata)])
                    begin
                        used_reg[FW'(ram_rdata)] <= 1'b0;
                        free_reg <= free_reg + CW'(1);
                    end
                    pcnt_reg[cur] <= last_pg;
                    state_reg     <= S_SHRINK_RD;
                end
                S_GROW:
                begin
                    if (fscan_reg[FW] || !(PW'(cur_cnt) < PW'(want_reg)))
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        if (ram_we)
                        begin
                            used_reg[fscan_reg[FW-1:0]] <= 1'b1;
                            free_reg      <= free_reg - CW'(1);
                            pcnt_reg[cur] <= cur_cnt + PW'(1);
                        end
                        fscan_reg <= fscan_reg + (FW+1)'(1);
                    end
                end
                S_XL_RD:
                begin
                    if (32'(rq_reg.page_number) >= 32'(cur_cnt))
                    begin
                        out_reg.status <= pfa_pkg::ST_BADPAGE;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_XL;
                    end
                end
                S_XL:
                begin
                    out_reg.frame <= ram_rdata;
                    state_reg     <= S_RESP;
                end
                S_RESP:
                begin
                    out_reg.free_frames <= 9'(free_reg);
                    out_valid_reg       <= 1'b1;
                    state_reg           <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `PFA_ASSERT_IMP(a_free_bound, clk, rst_n, 1'b1, free_reg <= CW'(NUM_FRAMES))
    `PFA_ASSERT_NXT(a_acc_busy, clk, rst_n, req.valid && req.ready, !req.ready)
    `PFA_ASSERT_IMP(a_div_once, clk, rst_n, dctl.start, state_reg == S_DISPATCH)
    `PFA_ASSERT_NXT(a_resp_valid, clk, rst_n, state_reg == S_RESP, rsp.valid)
endmodule

// File: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFR = 256;
    localparam int NSLOT = 16;
    localparam int NPG = 64;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [16:0] cfg_wdata;

    pfa_req_if req_ch ();
    pfa_rsp_if rsp_ch ();

    paged_frame_allocator_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .req(req_ch.sink),
        .rsp(rsp_ch.source)
    );

    // Allocator mirror.
    logic [16:0] mirror_page_size;
    bit frame_busy [NFR];
    int free_total;
    bit slot_live [NSLOT];
    logic [15:0] slot_pid [NSLOT];
    int slot_pages [NSLOT];
    logic [7:0] page_map [NSLOT][NPG];

    pfa_pkg::rsp_word_t expected_rsp_q [$];
    int fail_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;
    bit sending_done;

    // Live pids, used to steer random requests at real processes.
    logic [15:0] pid_pool [$];

    task automatic mirror_reset();
        mirror_page_size = 17'd32;
        free_total = NFR;
        foreach (frame_busy[f])
            frame_busy[f] = 1'b0;
        for (int s = 0; s < NSLOT; s++)
        begin
            slot_live[s] = 1'b0;
            slot_pid[s] = '0;
            slot_pages[s] = 0;
        end
    endtask

    function automatic void drop_pages(input int s, input int keep);
        int f;
        while (slot_pages[s] > keep)
        begin
            f = page_map[s][slot_pages[s] - 1];
            if (frame_busy[f])
            begin
                frame_busy[f] = 1'b0;
                free_total++;
            end
            slot_pages[s]--;
        end
    endfunction

    function automatic logic [2:0] resize_mirror(input int s, input logic [23:0] sz);
        longint ps;
        longint want;
        ps = mirror_page_size;
        if (ps == 0)
            ps = 1;
        if (ps > 65536)
            ps = 65536;
        want = (longint'(sz) + ps - 1) / ps;
        if (want > NPG)
            return pfa_pkg::ST_OOM;
        if (want <= slot_pages[s])
        begin
            drop_pages(s, int'(want));
            return pfa_pkg::ST_OK;
        end
        if (want - slot_pages[s] > free_total)
            return pfa_pkg::ST_OOM;
        for (int f = 0; f < NFR && slot_pages[s] < want; f++)
        begin
            if (!frame_busy[f])
            begin
                frame_busy[f] = 1'b1;
                free_total--;
                page_map[s][slot_pages[s]] = f[7:0];
                slot_pages[s]++;
            end
        end
        return pfa_pkg::ST_OK;
    endfunction

    function automatic pfa_pkg::rsp_word_t allocator_step(input pfa_pkg::req_word_t w);
        pfa_pkg::rsp_word_t r;
        int s;
        int k;
        s = -1;
        r = '0;
        for (int i = 0; i < NSLOT; i++)
            if (s < 0 && slot_live[i] && slot_pid[i] == w.pid)
                s = i;
        if (w.req_type == pfa_pkg::REQ_CREATE)
        begin
            if (s < 0)
            begin
                k = 0;
                while (k < NSLOT && slot_live[k])
                    k++;
                if (k >= NSLOT)
                    r.status = pfa_pkg::ST_NOSLOT;
                else
                begin
                    slot_live[k] = 1'b1;
                    slot_pid[k] = w.pid;
                    slot_pages[k] = 0;
                    pid_pool.push_back(w.pid);
                end
            end
        end
        else if (s < 0)
            r.status = pfa_pkg::ST_NOPROC;
        else if (w.req_type == pfa_pkg::REQ_FINISH)
        begin
            drop_pages(s, 0);
            slot_live[s] = 1'b0;
            foreach (pid_pool[i])
                if (pid_pool[i] == w.pid)
                begin
                    pid_pool.delete(i);
                    break;
                end
        end
        else if (w.req_type == pfa_pkg::REQ_RESIZE)
            r.status = resize_mirror(s, w.new_size);
        else if (w.page_number >= slot_pages[s])
            r.status = pfa_pkg::ST_BADPAGE;
        else
            r.frame = page_map[s][w.page_number];
        r.free_frames = free_total[8:0];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Result checker and receiver stalls.
    initial
    begin
        pfa_pkg::rsp_word_t exp_w;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("result with nothing expected: %h", rsp_ch.data);
                    fail_count++;
                end
                else
                begin
                    exp_w = expected_rsp_q.pop_front();
                    if (rsp_ch.data.status !== exp_w.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_w.status,
                               rsp_ch.data.status);
                        fail_count++;
                    end
                    if (rsp_ch.data.frame !== exp_w.frame)
                    begin
                        $error("frame: expected %0d, got %0d", exp_w.frame,
                               rsp_ch.data.frame);
                        fail_count++;
                    end
                    if (rsp_ch.data.free_frames !== exp_w.free_frames)
                    begin
                        $error("free_frames: expected %0d, got %0d", exp_w.free_frames,
                               rsp_ch.data.free_frames);
                        fail_count++;
                    end
                end
            end
            if (hold_off > 0)
            begin
                hold_off--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one request word and records its expected result once accepted.
    // Valid stays high after the accept so that a following word can go out back to back.
    task automatic send_word(input pfa_pkg::req_word_t w, input bit typed,
                             input pfa_pkg::rsp_word_t typed_rsp);
        pfa_pkg::rsp_word_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= w;
        do
            @(posedge clk);
        while (!req_ch.ready);
        p = allocator_step(w);
        if (typed && p !== typed_rsp)
        begin
            $error("directed row %h: typed %h, predictor %h", w, typed_rsp, p);
            fail_count++;
        end
        expected_rsp_q.push_back(typed ? typed_rsp : p);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_page_size(input logic [16:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        mirror_page_size = v;
    endtask

    function automatic pfa_pkg::req_word_t random_word();
        pfa_pkg::req_word_t w;
        int pick;
        w.req_type = 2'($urandom_range(3));
        w.new_size = 24'($urandom);
        w.page_number = 16'($urandom);
        if ($urandom_range(99) < 85 && pid_pool.size() != 0)
            w.pid = pid_pool[$urandom_range(pid_pool.size() - 1)];
        else if ($urandom_range(1))
            w.pid = 16'($urandom_range(40));
        else
            w.pid = 16'($urandom);
        if (w.req_type == pfa_pkg::REQ_CREATE && pid_pool.size() > 10 && $urandom_range(1))
            w.req_type = pfa_pkg::REQ_RESIZE;
        pick = $urandom_range(99);
        if (w.req_type == pfa_pkg::REQ_RESIZE && pick < 80)
            w.new_size = 24'($urandom_range(mirror_page_size * 20 + 1));
        if (w.req_type == pfa_pkg::REQ_TRANSLATE && pick < 85)
            w.page_number = 16'($urandom_range(20));
        return w;
    endfunction

    typedef struct {
        pfa_pkg::req_word_t w;
        bit typed;
        pfa_pkg::rsp_word_t r;
    } stim_row_t;

    stim_row_t rows [$];

    function automatic stim_row_t mk(input logic [1:0] t, input logic [15:0] p,
                                     input logic [23:0] sz, input logic [15:0] pg,
                                     input bit typed, input logic [2:0] st,
                                     input logic [7:0] fr, input logic [8:0] ff);
        stim_row_t row;
        row.w = '{req_type: t, pid: p, new_size: sz, page_number: pg};
        row.typed = typed;
        row.r = '{status: st, frame: fr, free_frames: ff};
        return row;
    endfunction

    initial
    begin
        pfa_pkg::req_word_t w;
        int phase_items;
        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        mirror_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back(mk(pfa_pkg::REQ_TRANSLATE, 16'hFFFF, 0, 0, 1,
                          pfa_pkg::ST_NOPROC, 0, 256));
        rows.push_back(mk(pfa_pkg::REQ_FINISH, 16'h0000, 0, 0, 1, pfa_pkg::ST_NOPROC, 0, 256));
        rows.push_back(mk(pfa_pkg::REQ_RESIZE, 16'h1234, 24'd64, 0, 1,
                          pfa_pkg::ST_NOPROC, 0, 256));
        rows.push_back(mk(pfa_pkg::REQ_CREATE, 16'hFFFF, 0, 0, 1, pfa_pkg::ST_OK, 0, 256));
        rows.push_back(mk(pfa_pkg::REQ_CREATE, 16'hFFFF, 0, 0, 1, pfa_pkg::ST_OK, 0, 256));
        rows.push_back(mk(pfa_pkg::REQ_RESIZE, 16'hFFFF, 24'd65, 0, 1, pfa_pkg::ST_OK, 0, 253));
        rows.push_back(mk(pfa_pkg::REQ_TRANSLATE, 16'hFFFF, 0, 16'd2, 1,
                          pfa_pkg::ST_OK, 2, 253));
        rows.push_back(mk(pfa_pkg::REQ_TRANSLATE, 16'hFFFF, 0, 16'd3, 1,
                          pfa_pkg::ST_BADPAGE, 0, 253));
        rows.push_back(mk(pfa_pkg::REQ_TRANSLATE, 16'hFFFF, 0, 16'hFFFF, 1,
                          pfa_pkg::ST_BADPAGE, 0, 253));
        rows.push_back(mk(pfa_pkg::REQ_RESIZE, 16'hFFFF, 24'hFFFFFF, 0, 1,
                          pfa_pkg::ST_OOM, 0, 253));
        rows.push_back(mk(pfa_pkg::REQ_RESIZE, 16'hFFFF, 24'd2048, 0, 1,
                          pfa_pkg::ST_OK, 0, 192));
        rows.push_back(mk(pfa_pkg::REQ_RESIZE, 16'hFFFF, 24'd2049, 0, 1,
                          pfa_pkg::ST_OOM, 0, 192));
        rows.push_back(mk(pfa_pkg::REQ_RESIZE, 16'hFFFF, 24'd33, 0, 1, pfa_pkg::ST_OK, 0, 254));
        rows.push_back(mk(pfa_pkg::REQ_CREATE, 16'h0000, 0, 0, 1, pfa_pkg::ST_OK, 0, 254));
        rows.push_back(mk(pfa_pkg::REQ_RESIZE, 16'h0000, 24'd32, 0, 1, pfa_pkg::ST_OK, 0, 253));
        rows.push_back(mk(pfa_pkg::REQ_TRANSLATE, 16'h0000, 0, 0, 1, pfa_pkg::ST_OK, 2, 253));
        rows.push_back(mk(pfa_pkg::REQ_RESIZE, 16'hFFFF, 24'd0, 0, 1, pfa_pkg::ST_OK, 0, 255));
        rows.push_back(mk(pfa_pkg::REQ_FINISH, 16'hFFFF, 0, 0, 1, pfa_pkg::ST_OK, 0, 255));
        rows.push_back(mk(pfa_pkg::REQ_TRANSLATE, 16'hFFFF, 0, 0, 1,
                          pfa_pkg::ST_NOPROC, 0, 255));
        for (int i = 1; i <= 15; i++)
            rows.push_back(mk(pfa_pkg::REQ_CREATE, 16'(i * 4099), 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(pfa_pkg::REQ_CREATE, 16'h5555, 0, 0, 1, pfa_pkg::ST_NOSLOT, 0, 255));
        rows.push_back(mk(pfa_pkg::REQ_FINISH, 16'h0000, 0, 0, 1, pfa_pkg::ST_OK, 0, 256));
        foreach (rows[i])
            send_word(rows[i].w, rows[i].typed, rows[i].r);

        // Random phases under several page sizes and idling mixes.
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0: write_page_size(17'd0);
                1: write_page_size(17'h1FFFF);
                2: write_page_size(17'd1);
                3: write_page_size(17'd65536);
                4: write_page_size(17'($urandom_range(2, 300)));
                default: write_page_size(17'($urandom));
            endcase
            send_idle_pct = (ph == 1 || ph == 5) ? 88 : (ph == 3 ? 26 : 0);
            recv_stall_pct = (ph == 2 || ph == 4) ? 88 : (ph == 3 ? 26 : 0);
            if (ph == 0)
                hold_off = 3000;
            phase_items = 90;
            for (int i = 0; i < phase_items; i++)
            begin
                w = random_word();
                send_word(w, 0, '0);
            end
        end
        drain();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
